// ===== rtl/rcia_pkg.sv =====
// Shared types and constants for the reference-counted id allocator.
// No dependencies; every other file in rtl/ imports this package.
package rcia_pkg;

    localparam int ID_W  = 10;
    localparam int CMD_W = 2;
    localparam int ST_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC_NEW = 2'd0,
        CMD_ALLOC_REQ = 2'd1,
        CMD_RELEASE   = 2'd2,
        CMD_ADD_REF   = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 2'd0,
        ST_EXHAUSTED  = 2'd1,
        ST_STACK_FULL = 2'd2,
        ST_SATURATED  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        FSM_CLEAR = 2'd0,
        FSM_IDLE  = 2'd1,
        FSM_EXEC  = 2'd2
    } fsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_step;
        logic capture;
        logic execute;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_done;
    } dp_status_t;

endpackage

// ===== rtl/rcia_ctrl.sv =====
// Controller state machine of the id allocator: clearing pass, accept, execute.
// Depends on rcia_pkg; drives the handshake and the datapath command struct.
module rcia_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rcia_pkg::dp_status_t dp_status,
    output rcia_pkg::ctrl_t      ctrl
);
    import rcia_pkg::*;

    fsm_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_CLEAR: begin
                if (dp_status.clear_done) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    state_next = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_CLEAR;
        endcase
    end

    always_comb begin
        ctrl           = '0;
        s_ready        = 1'b0;
        case (state_reg)
            FSM_CLEAR: ctrl.clear_step = 1'b1;
            FSM_IDLE: begin
                s_ready      = 1'b1;
                ctrl.capture = s_valid;
            end
            FSM_EXEC: ctrl.execute = out_free;
            default: ctrl = '0;
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.execute) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_valid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= FSM_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A result is only written into the output register when it is free.
    a_exec_into_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.execute |-> (!out_valid_reg || m_ready))
        else $error("result loaded over an untaken word");

    // Each accepted word is executed before the next one is taken.
    a_capture_then_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.capture |=> (!s_ready && !ctrl.clear_step))
        else $error("new word taken before the previous one was executed");
`endif

endmodule

// ===== rtl/rcia_dp.sv =====
// Datapath of the id allocator: free stack memory, count memory, marks and result.
// Depends on rcia_pkg; steered by the command struct from rcia_ctrl.
module rcia_dp #(
    parameter int ID_COUNT    = 1024,
    parameter int COUNT_WIDTH = 8
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  rcia_pkg::ctrl_t             ctrl,
    output rcia_pkg::dp_status_t        dp_status,
    input  rcia_pkg::cmd_t              in_cmd,
    input  logic [rcia_pkg::ID_W-1:0]   in_id,
    output logic [rcia_pkg::ID_W-1:0]   granted_id,
    output rcia_pkg::status_t           status
);
    import rcia_pkg::*;

    localparam int HW_W     = $clog2(ID_COUNT + 1);
    localparam int SP_AW    = $clog2(ID_COUNT);
    localparam int RC_DEPTH = (ID_COUNT < (1 << ID_W)) ? ID_COUNT : (1 << ID_W);
    localparam int RC_AW    = $clog2(RC_DEPTH);
    localparam int WW       = HW_W + ID_W;

    logic [ID_W-1:0]        stack_mem [ID_COUNT];
    logic [COUNT_WIDTH-1:0] rc_mem    [RC_DEPTH];

    cmd_t                   cmd_reg;
    logic [ID_W-1:0]        id_reg;
    logic [ID_W-1:0]        stack_rdata_reg;
    logic [COUNT_WIDTH-1:0] rc_rdata_reg;
    logic [HW_W-1:0]        free_count_reg, free_count_next;
    logic [HW_W-1:0]        high_water_reg, high_water_next;
    logic [RC_AW-1:0]       clear_idx_reg;
    logic [ID_W-1:0]        granted_reg, granted_next;
    status_t                status_reg, status_next;

    logic                   stack_empty, stack_full, id_in_range;
    logic                   push, rc_upd, rc_we;
    logic [COUNT_WIDTH-1:0] rc_upd_val, rc_wdata;
    logic [RC_AW-1:0]       rc_wr_idx;
    logic [SP_AW-1:0]       top_idx, push_idx;

    assign stack_empty = (free_count_reg == '0);
    assign stack_full  = (free_count_reg == HW_W'(ID_COUNT));
    assign id_in_range = (WW'(id_reg) < WW'(ID_COUNT));
    assign top_idx     = SP_AW'(free_count_reg - HW_W'(1));
    assign push_idx    = SP_AW'(free_count_reg);
    assign dp_status.clear_done = (clear_idx_reg == RC_AW'(RC_DEPTH - 1));

    // One command: at most one pop or push and one count update.
    always_comb begin
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        granted_next    = '0;
        status_next     = ST_OK;
        push            = 1'b0;
        rc_upd          = 1'b0;
        rc_upd_val      = rc_rdata_reg;
        case (cmd_reg)
            CMD_ALLOC_NEW: begin
                if (!stack_empty) begin
                    granted_next    = stack_rdata_reg;
                    free_count_next = free_count_reg - HW_W'(1);
                end else if (!stack_full && (high_water_reg < HW_W'(ID_COUNT))) begin
                    granted_next    = ID_W'(high_water_reg);
                    high_water_next = high_water_reg + HW_W'(1);
                end else if (high_water_reg < HW_W'(ID_COUNT)) begin
                    granted_next    = ID_W'(high_water_reg);
                    high_water_next = high_water_reg + HW_W'(1);
                end else begin
                    status_next = ST_EXHAUSTED;
                end
            end
            CMD_ALLOC_REQ: begin
                if (!stack_empty) begin
                    granted_next    = stack_rdata_reg;
                    free_count_next = free_count_reg - HW_W'(1);
                end else if (!id_in_range) begin
                    status_next = ST_EXHAUSTED;
                end else begin
                    granted_next = id_reg;
                    if (WW'(id_reg) >= WW'(high_water_reg)) begin
                        high_water_next = HW_W'(WW'(id_reg) + WW'(1));
                    end
                end
            end
            CMD_RELEASE: begin
                if (id_in_range) begin
                    if (rc_rdata_reg >= COUNT_WIDTH'(2)) begin
                        rc_upd     = 1'b1;
                        rc_upd_val = rc_rdata_reg - COUNT_WIDTH'(1);
                    end else if (stack_full) begin
                        status_next = ST_STACK_FULL;
                    end else begin
                        rc_upd          = 1'b1;
                        rc_upd_val      = '0;
                        push            = 1'b1;
                        free_count_next = free_count_reg + HW_W'(1);
                    end
                end
            end
            CMD_ADD_REF: begin
                if (id_in_range) begin
                    if (rc_rdata_reg == '0) begin
                        rc_upd     = 1'b1;
                        rc_upd_val = COUNT_WIDTH'(2);
                    end else if (rc_rdata_reg == '1) begin
                        status_next = ST_SATURATED;
                    end else begin
                        rc_upd     = 1'b1;
                        rc_upd_val = rc_rdata_reg + COUNT_WIDTH'(1);
                    end
                end
            end
            default: status_next = ST_OK;
        endcase
    end

    // The clearing pass and the command share the single write port.
    assign rc_we     = ctrl.clear_step || (ctrl.execute && rc_upd);
    assign rc_wr_idx = ctrl.clear_step ? clear_idx_reg : RC_AW'(id_reg);
    assign rc_wdata  = ctrl.clear_step ? '0 : rc_upd_val;

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            stack_rdata_reg <= stack_mem[top_idx];
            rc_rdata_reg    <= rc_mem[RC_AW'(in_id)];
        end
        if (ctrl.execute && push) begin
            stack_mem[push_idx] <= id_reg;
        end
        if (rc_we) begin
            rc_mem[rc_wr_idx] <= rc_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.capture) begin
            cmd_reg <= in_cmd;
            id_reg  <= in_id;
        end
        if (ctrl.execute) begin
            granted_reg <= granted_next;
            status_reg  <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            free_count_reg <= '0;
            high_water_reg <= '0;
            clear_idx_reg  <= '0;
        end else begin
            if (ctrl.clear_step) begin
                clear_idx_reg <= clear_idx_reg + RC_AW'(1);
            end
            if (ctrl.execute) begin
                free_count_reg <= free_count_next;
                high_water_reg <= high_water_next;
            end
        end
    end

    assign granted_id = granted_reg;
    assign status     = status_reg;

`ifndef NO_ASSERTIONS
    a_free_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        free_count_reg <= HW_W'(ID_COUNT))
        else $error("free stack count beyond its depth");

    a_high_water_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        high_water_reg <= HW_W'(ID_COUNT))
        else $error("high-water mark beyond the id space");

    // A failed command never hands out an id.
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.execute && (status_next != ST_OK)) |=> (granted_reg == '0))
        else $error("id granted with a failure status");
`endif

endmodule

// ===== rtl/refcounted_id_allocator_top.sv =====
// Top level of the reference-counted id allocator; joins rcia_ctrl and rcia_dp.
// An accepted word is captured into the command and read registers; its result is then loaded
// into the output register once that register is free, and otherwise waits for it.
// A new command is not taken until the previous one has executed, as the registered memory read
// is followed by the update write; the next word is accepted while the previous result waits.
// Reset: the count memory is cleared by a pass over min(ID_COUNT, 1024) entries, s_axis_tready low.
module refcounted_id_allocator_top #(
    parameter int ID_COUNT    = 1024,
    parameter int COUNT_WIDTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Fields from bit 0 up: command [1:0], target_id [11:2], zero padding [15:12].
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Fields from bit 0 up: granted_id [9:0], status [11:10], zero padding [15:12].
    output logic [15:0] m_axis_tdata
);
    import rcia_pkg::*;

    // The controller decides when a word is taken, executed and offered; the
    // datapath holds the free stack, the counts and the result register.
    ctrl_t           ctrl;
    dp_status_t      dp_status;
    logic [ID_W-1:0] granted_id;
    status_t         status;

    rcia_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_axis_tvalid),
        .s_ready   (s_axis_tready),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .dp_status (dp_status),
        .ctrl      (ctrl)
    );

    rcia_dp #(
        .ID_COUNT    (ID_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .dp_status  (dp_status),
        .in_cmd     (cmd_t'(s_axis_tdata[CMD_W-1:0])),
        .in_id      (s_axis_tdata[CMD_W +: ID_W]),
        .granted_id (granted_id),
        .status     (status)
    );

    // The upper bits of the result word are always zero.
    assign m_axis_tdata = {4'b0000, status, granted_id};

endmodule

// ===== test/refcounted_id_allocator_top_tb.sv =====
// Self-checking testbench for refcounted_id_allocator_top. Words are checked in order
// against an in-bench model of the free stack, high-water mark and reference counts.
// Depends on rcia_pkg and the refcounted_id_allocator_top RTL only.
`timescale 1ns / 1ps

module refcounted_id_allocator_top_tb;

    import rcia_pkg::*;

    localparam int ID_COUNT    = 1024;
    localparam int COUNT_WIDTH = 8;
    localparam int COUNT_CEIL  = (1 << COUNT_WIDTH) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;
    localparam int EXP_DEPTH   = 16;
    localparam int HELD_MAX    = 512;

    // Ids used by the long special-case tests.
    localparam logic [ID_W-1:0] TOP_ID = 10'h3FF;
    localparam logic [ID_W-1:0] SAT_ID = 10'h2BC;
    localparam logic [ID_W-1:0] OVF_ID = 10'h2AA;

    typedef struct packed {
        logic [ID_W-1:0] id;
        status_t         st;
    } grant_t;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // Fields from bit 0 up: command [1:0], target_id [11:2], zero padding [15:12].
    logic [15:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // Fields from bit 0 up: granted_id [9:0], status [11:10], zero padding [15:12].
    logic [15:0] m_axis_tdata;

    // Mirror of the allocator state, updated when a command word is accepted.
    logic [ID_W-1:0]        free_ids   [ID_COUNT];
    logic [COUNT_WIDTH-1:0] ref_counts [ID_COUNT];
    int                     stack_depth = 0;
    int                     mark        = 0;

    // Expected result words in order; the write and read counts only ever grow.
    grant_t exp_words [EXP_DEPTH];
    int     exp_wr      = 0;
    int     exp_rd      = 0;
    grant_t last_grant;
    int     errors      = 0;
    int     cycle_count = 0;
    int     burst_left  = 0;

    refcounted_id_allocator_top #(
        .ID_COUNT    (ID_COUNT),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Runaway guard; the slowest correct run stays well below this.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("refcounted_id_allocator_top_tb: errors");
            $finish;
        end
    end

    // Applies one command to the mirror and returns the word the block should send back.
    function automatic grant_t predict_grant(cmd_t cmd, logic [ID_W-1:0] id);
        grant_t g;
        int     cnt;
        g.id = '0;
        g.st = ST_OK;
        cnt  = ref_counts[id];
        case (cmd)
            CMD_ALLOC_NEW, CMD_ALLOC_REQ: begin
                if (stack_depth > 0) begin
                    // A non-empty stack wins for both allocate commands.
                    stack_depth--;
                    g.id = free_ids[stack_depth];
                end else if (cmd == CMD_ALLOC_NEW) begin
                    if (mark < ID_COUNT) begin
                        g.id = ID_W'(mark);
                        mark++;
                    end else begin
                        g.st = ST_EXHAUSTED;
                    end
                end else if (int'(id) >= ID_COUNT) begin
                    g.st = ST_EXHAUSTED;
                end else begin
                    if (int'(id) >= mark) mark = int'(id) + 1;
                    g.id = id;
                end
            end
            CMD_RELEASE: begin
                if (cnt >= 2) begin
                    ref_counts[id] = COUNT_WIDTH'(cnt - 1);
                end else if (stack_depth >= ID_COUNT) begin
                    g.st = ST_STACK_FULL;
                end else begin
                    ref_counts[id]        = '0;
                    free_ids[stack_depth] = id;
                    stack_depth++;
                end
            end
            CMD_ADD_REF: begin
                if (cnt == 0) ref_counts[id] = COUNT_WIDTH'(2);
                else if (cnt >= COUNT_CEIL) g.st = ST_SATURATED;
                else ref_counts[id] = COUNT_WIDTH'(cnt + 1);
            end
            default: g.st = ST_OK;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (errors < PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // Drives one word; bursts of random length are separated by random gaps.
    task automatic send_word(input cmd_t cmd, input logic [ID_W-1:0] id);
        if (burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0000, id, cmd};
        @(posedge aclk);
        while (s_axis_tready !== 1'b1) @(posedge aclk);
        last_grant = predict_grant(cmd, id);
        exp_words[exp_wr % EXP_DEPTH] = last_grant;
        exp_wr++;
        @(negedge aclk);
    endtask

    // Holds the sender off until every outstanding word has come back.
    task automatic wait_drained;
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        @(negedge aclk);
        burst_left = 0;
    endtask

    // Mostly small ids so that references and releases meet allocated ones.
    function automatic logic [ID_W-1:0] pick_id;
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return ID_W'($urandom_range(0, 31));
        if (r < 85) return ID_W'($urandom_range(0, 127));
        return ID_W'($urandom_range(0, ID_COUNT - 1));
    endfunction

    // The receiver changes its stall pattern after each run of random length.
    int stall_mode = 0;
    int stall_left = 0;
    int stall_tick = 0;
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= 1'($urandom_range(0, 1));
            2:       m_axis_tready <= (stall_tick % 3 == 0);
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // Compares every accepted result word with the oldest expectation.
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_axis_tvalid === 1'b1 && m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch("result word with nothing expected, granted_id",
                                int'(m_axis_tdata[9:0]), -1);
            end else begin
                want = exp_words[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_axis_tdata[9:0] !== want.id)
                    report_mismatch("granted_id", int'(m_axis_tdata[9:0]), int'(want.id));
                if (m_axis_tdata[11:10] !== want.st)
                    report_mismatch("status", int'(m_axis_tdata[11:10]), int'(want.st));
            end
        end
    end

    // Allocation from the mark, requested ids, stack reuse and reference counting.
    task automatic test_basics;
        send_word(CMD_ALLOC_NEW, TOP_ID);  // target ignored, mark gives 0
        send_word(CMD_ALLOC_NEW, 10'h000);
        send_word(CMD_ALLOC_REQ, 10'd5);   // raises the mark past 5
        send_word(CMD_ALLOC_REQ, 10'd2);   // below the mark, mark unchanged
        send_word(CMD_RELEASE,   10'd0);   // absent count: pushed at once
        send_word(CMD_ALLOC_REQ, 10'd9);   // stack not empty: pops 0, 9 ignored
        send_word(CMD_ADD_REF,   10'd1);
        send_word(CMD_ADD_REF,   10'd1);
        send_word(CMD_RELEASE,   10'd1);
        send_word(CMD_RELEASE,   10'd1);
        send_word(CMD_RELEASE,   10'd1);   // count reaches zero: pushed
        send_word(CMD_ALLOC_NEW, 10'd0);
        send_word(CMD_RELEASE,   TOP_ID);  // never allocated, still pushed
        send_word(CMD_ADD_REF,   OVF_ID);
        send_word(CMD_RELEASE,   OVF_ID);
        send_word(CMD_RELEASE,   10'h155);
        send_word(CMD_ALLOC_NEW, 10'h155);
        send_word(CMD_ALLOC_NEW, 10'h2AA);
        send_word(CMD_ALLOC_NEW, 10'h000);
        send_word(CMD_ADD_REF,   TOP_ID);
        send_word(CMD_RELEASE,   TOP_ID);
        send_word(CMD_RELEASE,   TOP_ID);
        send_word(CMD_RELEASE,   TOP_ID);  // double release of a free id
        send_word(CMD_ALLOC_NEW, 10'h3FF);
    endtask

    // Allocate, reference and release sequences on held ids, with some noise.
    task automatic test_random_traffic(input int n);
        logic [ID_W-1:0] held [HELD_MAX];
        logic [ID_W-1:0] id;
        int              held_n;
        int              r;
        int              k;
        held_n = 0;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) wait_drained();
            r = $urandom_range(0, 99);
            k = -1;
            if (r < 8) begin
                send_word(cmd_t'($urandom_range(0, 3)), ID_W'($urandom_range(0, ID_COUNT - 1)));
            end else if (r < 33) begin
                send_word(CMD_ALLOC_NEW, ID_W'($urandom_range(0, ID_COUNT - 1)));
            end else if (r < 45) begin
                send_word(CMD_ALLOC_REQ, pick_id());
            end else begin
                if (held_n > 0 && $urandom_range(0, 4) != 0) begin
                    k  = $urandom_range(0, held_n - 1);
                    id = held[k];
                end else begin
                    id = pick_id();
                end
                if (r < 73) begin
                    send_word(CMD_ADD_REF, id);
                end else begin
                    send_word(CMD_RELEASE, id);
                    // The last held id takes the place of the one that was freed.
                    if (k >= 0 && last_grant.st == ST_OK && ref_counts[id] == 0) begin
                        held[k] = held[held_n - 1];
                        held_n--;
                    end
                end
            end
            if (r >= 8 && r < 45 && last_grant.st == ST_OK && held_n < HELD_MAX) begin
                held[held_n] = last_grant.id;
                held_n++;
            end
        end
    endtask

    // Empties the stack, then takes the mark to its end.
    task automatic test_mark_exhaustion;
        while (stack_depth > 0) send_word(CMD_ALLOC_NEW, 10'd0);
        send_word(CMD_ALLOC_REQ, TOP_ID);
        send_word(CMD_ALLOC_NEW, 10'd0);
        send_word(CMD_ALLOC_REQ, 10'd3);
        send_word(CMD_ALLOC_NEW, TOP_ID);
    endtask

    task automatic test_count_saturation;
        while (ref_counts[SAT_ID] != COUNT_WIDTH'(COUNT_CEIL)) send_word(CMD_ADD_REF, SAT_ID);
        send_word(CMD_ADD_REF, SAT_ID);
        send_word(CMD_RELEASE, SAT_ID);
        send_word(CMD_ADD_REF, SAT_ID);
        send_word(CMD_ADD_REF, SAT_ID);
    endtask

    // Fills the stack by repeated release of one id, overflows it, then drains it.
    task automatic test_stack_overflow;
        while (stack_depth < ID_COUNT) send_word(CMD_RELEASE, OVF_ID);
        send_word(CMD_RELEASE, OVF_ID);
        send_word(CMD_ADD_REF, 10'h155);
        send_word(CMD_RELEASE, 10'h155);   // count drops to one, no push needed
        send_word(CMD_RELEASE, 10'h155);   // needs a push: dropped, count kept
        send_word(CMD_ALLOC_REQ, 10'h155);
        send_word(CMD_RELEASE, 10'h155);
        while (stack_depth > 0) send_word(CMD_ALLOC_NEW, 10'd0);
        send_word(CMD_ALLOC_NEW, 10'd0);
    endtask

    initial begin
        for (int i = 0; i < ID_COUNT; i++) ref_counts[i] = '0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_basics();
        test_random_traffic(500);
        test_mark_exhaustion();
        test_count_saturation();
        test_stack_overflow();

        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0) begin
            $display("refcounted_id_allocator_top_tb: clean");
        end else begin
            $display("refcounted_id_allocator_top_tb: errors");
        end
        $finish;
    end

endmodule
